@@ design/dnsle_pkg.sv @@
package dnsle_pkg;

   localparam logic [7:0] SEPARATOR = 8'h2E;
   localparam int unsigned TAIL_LEN = 5;
   localparam int unsigned TAIL_IW = 3;

   typedef struct packed {
      logic [7:0] name_char;
      logic       is_last_char;
   } req_data_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_byte;
      logic       label_overflow;
   } rsp_data_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic load_len;
      logic load_data;
      logic load_tail;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_free;
      logic count_zero;
      logic data_last;
      logic tail_end;
   } status_type;

   // Terminator followed by QTYPE A and QCLASS IN.
   function automatic logic [7:0] tail_byte(input logic [TAIL_IW-1:0] idx);
      logic [7:0] b;
      unique case (idx)
         3'd0: b = 8'h00;
         3'd1: b = 8'h00;
         3'd2: b = 8'h01;
         3'd3: b = 8'h00;
         3'd4: b = 8'h01;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

@@ design/dns_name_label_encoder.sv @@
// Ordinary characters: one per cycle, stored in the label buffer up to MAX_LABEL, no output.
// A dot or the last character closes a label: the length byte and the label bytes leave
// one per cycle from the output register, unless rsp_ready holds them back.
// The end of a name adds the terminator and the four type/class bytes, one per cycle unless held.
// Reset is synchronous and clears the controller, the label count and the output valid;
// the label buffer is not cleared.
module dns_name_label_encoder
   import dnsle_pkg::*;
#(
   parameter int unsigned MAX_LABEL = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_data_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_data_type rsp_data
);

   cmd_type    cmd;
   status_type status;

   dnsle_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .status    (status),
      .cmd       (cmd)
   );

   dnsle_datapath #(
      .MAX_LABEL (MAX_LABEL)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // A closing item always starts an emission, so no new item is taken next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready &&
       (req_data.is_last_char || (req_data.name_char == SEPARATOR))) |=> !req_ready)
      else $error("closing item did not start an emission");

   // The final byte is the class low byte and never carries the overflow flag.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.last_byte) |->
         (rsp_data.out_byte == 8'h01) && !rsp_data.label_overflow)
      else $error("bad final byte");

   // Only one emission command is issued at a time, and never while an item is taken.
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.accept, cmd.load_len, cmd.load_data, cmd.load_tail}))
      else $error("conflicting datapath commands");

endmodule

@@ design/dnsle_datapath.sv @@
module dnsle_datapath
   import dnsle_pkg::*;
#(
   parameter int unsigned MAX_LABEL = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  req_data_type req_data,
   input  cmd_type      cmd,
   output status_type   status,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_data_type rsp_data
);

   localparam int unsigned CW = $clog2(MAX_LABEL + 1);
   localparam int unsigned AW = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1;
   localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_LABEL);

   logic [7:0]        store_mem [MAX_LABEL];
   logic [7:0]        rd_data_ff;
   logic [CW-1:0]     count_ff, count_in;
   logic              ovf_ff, ovf_in;
   logic [AW-1:0]     idx_ff, idx_in;
   logic [TAIL_IW-1:0] tail_idx_ff, tail_idx_in;
   logic              out_valid_ff, out_valid_in;
   rsp_data_type      out_data_ff, out_data_in;

   logic              is_dot;
   logic              store_wr;
   logic [CW-1:0]     idx_next;
   logic              rd_en;
   logic [AW-1:0]     rd_addr;
   logic              flush_done;

   assign is_dot   = (req_data.name_char == SEPARATOR);
   assign store_wr = cmd.accept && !is_dot && (count_ff < MAX_COUNT);
   assign idx_next = CW'(idx_ff) + CW'(1);

   assign status.out_free   = !out_valid_ff || rsp_ready;
   assign status.count_zero = (count_ff == '0);
   assign status.data_last  = (idx_next == count_ff);
   assign status.tail_end   = (tail_idx_ff == TAIL_IW'(TAIL_LEN - 1));

   assign flush_done = (cmd.load_len && status.count_zero) ||
                       (cmd.load_data && status.data_last);

   // The read register runs one byte ahead of the output register.
   assign rd_en   = cmd.load_len || (cmd.load_data && !status.data_last);
   assign rd_addr = cmd.load_len ? '0 : idx_next[AW-1:0];

   always_ff @(posedge clock) begin
      if (store_wr) begin
         store_mem[count_ff[AW-1:0]] <= req_data.name_char;
      end
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   always_comb begin
      count_in = count_ff;
      ovf_in   = ovf_ff;
      if (flush_done) begin
         count_in = '0;
         ovf_in   = 1'b0;
      end else if (cmd.accept && !is_dot) begin
         if (count_ff < MAX_COUNT) begin
            count_in = count_ff + CW'(1);
         end else begin
            ovf_in = 1'b1;
         end
      end
   end

   always_comb begin
      idx_in      = idx_ff;
      tail_idx_in = tail_idx_ff;
      if (cmd.load_len) begin
         idx_in = '0;
      end else if (cmd.load_data) begin
         idx_in = idx_next[AW-1:0];
      end
      if (cmd.load_tail) begin
         tail_idx_in = status.tail_end ? '0 : tail_idx_ff + TAIL_IW'(1);
      end
   end

   always_comb begin
      out_data_in  = out_data_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      if (cmd.load_len) begin
         out_data_in  = '{out_byte: 8'(count_ff), last_byte: 1'b0, label_overflow: ovf_ff};
         out_valid_in = 1'b1;
      end else if (cmd.load_data) begin
         out_data_in  = '{out_byte: rd_data_ff, last_byte: 1'b0, label_overflow: ovf_ff};
         out_valid_in = 1'b1;
      end else if (cmd.load_tail) begin
         out_data_in  = '{out_byte: tail_byte(tail_idx_ff), last_byte: status.tail_end,
                          label_overflow: 1'b0};
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         tail_idx_ff  <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         tail_idx_ff  <= tail_idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

@@ design/dnsle_controller.sv @@
module dnsle_controller
   import dnsle_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_data_type req_data,
   input  status_type   status,
   output cmd_type      cmd
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_LEN  = 4'b0010,
      ST_DATA = 4'b0100,
      ST_TAIL = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      flush_two_ff, flush_two_in;
   logic      tail_ff, tail_in;

   logic      is_dot;
   logic      flush_done;
   state_type after_flush;

   assign is_dot     = (req_data.name_char == SEPARATOR);
   assign req_ready  = (state_ff == ST_IDLE);
   assign cmd.accept = req_valid && req_ready;

   assign cmd.load_len  = (state_ff == ST_LEN)  && status.out_free;
   assign cmd.load_data = (state_ff == ST_DATA) && status.out_free;
   assign cmd.load_tail = (state_ff == ST_TAIL) && status.out_free;

   assign flush_done = (cmd.load_len && status.count_zero) ||
                       (cmd.load_data && status.data_last);

   // A dot on the last character closes two labels: its own and the empty one.
   always_comb begin
      if (flush_two_ff) begin
         after_flush = ST_LEN;
      end else if (tail_ff) begin
         after_flush = ST_TAIL;
      end else begin
         after_flush = ST_IDLE;
      end
   end

   always_comb begin
      state_in     = state_ff;
      flush_two_in = flush_two_ff;
      tail_in      = tail_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.accept) begin
               if (is_dot) begin
                  flush_two_in = req_data.is_last_char;
                  tail_in      = req_data.is_last_char;
                  state_in     = ST_LEN;
               end else if (req_data.is_last_char) begin
                  flush_two_in = 1'b0;
                  tail_in      = 1'b1;
                  state_in     = ST_LEN;
               end
            end
         end
         ST_LEN, ST_DATA: begin
            if (flush_done) begin
               state_in     = after_flush;
               flush_two_in = 1'b0;
            end else if (cmd.load_len) begin
               state_in = ST_DATA;
            end
         end
         ST_TAIL: begin
            if (cmd.load_tail && status.tail_end) begin
               state_in = ST_IDLE;
               tail_in  = 1'b0;
            end
         end
         default: begin
            state_in     = ST_IDLE;
            flush_two_in = 1'b0;
            tail_in      = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         flush_two_ff <= 1'b0;
         tail_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         flush_two_ff <= flush_two_in;
         tail_ff      <= tail_in;
      end
   end

endmodule

@@ tb/tb.sv @@
module tb;
   import dnsle_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned LABEL_CAP = 32;
   // Zero terminator, then QTYPE A and QCLASS IN.
   localparam logic [39:0] QUESTION_TAIL = 40'h00_00_01_00_01;
   localparam int unsigned RANDOM_ITEMS = 150;
   localparam int unsigned HOLD_CYCLES = 300;

   typedef struct packed {
      logic [7:0]  ch;
      logic        last;
      logic [7:0]  reps;
      logic        typed;
      logic [55:0] seq;
   } stim_row_type;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   req_data_type req_data;
   logic         rsp_valid;
   logic         rsp_ready;
   rsp_data_type rsp_data;

   dns_name_label_encoder dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // Predictor state for the label being collected.
   logic [7:0]   label_chars [LABEL_CAP];
   int unsigned  label_len;
   bit           label_dropped;

   rsp_data_type wire_bytes_due [$];
   stim_row_type directed_rows [$];
   int unsigned  mismatch_count;
   int unsigned  sent_random;
   bit           quiet;
   bit           hold_go;

   always #10 clock = ~clock;

   function automatic rsp_data_type octet(input logic [7:0] b, input logic last,
                                          input logic ovf);
      rsp_data_type r;
      r.out_byte = b;
      r.last_byte = last;
      r.label_overflow = ovf;
      return r;
   endfunction

   function automatic bit idle_now();
      return !quiet && ($urandom_range(99) < 33);
   endfunction

   task automatic note_failure(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%s", msg);
   endtask

   task automatic flush_label(input bit record);
      int unsigned i;
      if (record) begin
         wire_bytes_due.push_back(octet(label_len[7:0], 1'b0, label_dropped));
         for (i = 0; i < label_len; i++)
            wire_bytes_due.push_back(octet(label_chars[i], 1'b0, label_dropped));
      end
      label_len = 0;
      label_dropped = 1'b0;
   endtask

   // Advances the label state by one character; the encoded bytes are queued when
   // record is set.
   task automatic encode_char(input req_data_type d, input bit record);
      int unsigned k;
      if (d.name_char == SEPARATOR)
         flush_label(record);
      else if (label_len < LABEL_CAP) begin
         label_chars[label_len] = d.name_char;
         label_len++;
      end else
         label_dropped = 1'b1;
      if (d.is_last_char) begin
         flush_label(record);
         if (record)
            for (k = 0; k < 5; k++)
               wire_bytes_due.push_back(octet(QUESTION_TAIL[39 - 8*k -: 8], k == 4, 1'b0));
      end
   endtask

   // Offers one item and updates the predictor on the falling edge after the transfer.
   task automatic offer(input req_data_type d, input bit record);
      while (idle_now()) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= d;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      @(negedge clock);
      encode_char(d, record);
   endtask

   task automatic add_row(input logic [7:0] ch, input logic last, input logic [7:0] reps,
                          input logic typed, input logic [55:0] seq);
      stim_row_type r;
      r.ch = ch;
      r.last = last;
      r.reps = reps;
      r.typed = typed;
      r.seq = seq;
      directed_rows.push_back(r);
   endtask

   task automatic random_name();
      req_data_type name_q [$];
      req_data_type d;
      int unsigned  labels;
      int unsigned  len;
      int unsigned  i;
      int unsigned  j;
      if ($urandom_range(9) < 2) begin
         // Noise: dots anywhere, last flag anywhere, possibly no end at all.
         len = $urandom_range(1, 12);
         for (i = 0; i < len; i++) begin
            d.name_char = ($urandom_range(3) == 0) ? SEPARATOR : 8'($urandom_range(255));
            d.is_last_char = ($urandom_range(7) == 0);
            name_q.push_back(d);
         end
      end else begin
         labels = $urandom_range(1, 4);
         for (i = 0; i < labels; i++) begin
            len = ($urandom_range(11) == 0) ? $urandom_range(30, 40) : $urandom_range(0, 9);
            for (j = 0; j < len; j++) begin
               d.name_char = 8'($urandom_range(255));
               if (d.name_char == SEPARATOR)
                  d.name_char = 8'h2D;
               d.is_last_char = 1'b0;
               name_q.push_back(d);
            end
            if (i + 1 < labels) begin
               d.name_char = SEPARATOR;
               d.is_last_char = 1'b0;
               name_q.push_back(d);
            end
         end
         if (name_q.size() == 0) begin
            d.name_char = SEPARATOR;
            name_q.push_back(d);
         end
         name_q[name_q.size() - 1].is_last_char = 1'b1;
      end
      foreach (name_q[i])
         offer(name_q[i], 1'b1);
      len = name_q.size();
      sent_random += len;
   endtask

   // Result checker.
   always @(posedge clock) begin
      rsp_data_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (wire_bytes_due.size() == 0)
            note_failure($sformatf("unexpected result byte %02h last %0b ovf %0b",
                                   rsp_data.out_byte, rsp_data.last_byte,
                                   rsp_data.label_overflow));
         else begin
            want = wire_bytes_due.pop_front();
            if (rsp_data.out_byte !== want.out_byte || rsp_data.last_byte !== want.last_byte
                || rsp_data.label_overflow !== want.label_overflow)
               note_failure($sformatf(
                  "mismatch: expected byte %02h last %0b ovf %0b, got %02h last %0b ovf %0b",
                  want.out_byte, want.last_byte, want.label_overflow, rsp_data.out_byte,
                  rsp_data.last_byte, rsp_data.label_overflow));
         end
      end
   end

   // Result receiver: random back-pressure plus one long hold while items keep coming.
   initial begin
      wait (!reset);
      forever begin
         @(negedge clock);
         if (hold_go) begin
            hold_go = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_ready <= !idle_now();
      end
   end

   initial begin
      #40_000_000;
      $display("dns_name_label_encoder verification failed");
      $finish;
   end

   initial begin
      req_data_type d;
      int unsigned  k;
      int unsigned  r;
      bit           paused;
      bit           hold_sent;
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      label_len = 0;
      label_dropped = 1'b0;
      mismatch_count = 0;
      quiet = 1'b0;
      hold_go = 1'b0;
      sent_random = 0;
      paused = 1'b0;
      hold_sent = 1'b0;

      // Empty name right after reset, single characters at the byte extremes.
      add_row(SEPARATOR, 1'b1, 8'd1, 1'b1, 56'h00_00_00_00_01_00_01);
      add_row(8'h61, 1'b1, 8'd1, 1'b1, 56'h01_61_00_00_01_00_01);
      add_row(8'h00, 1'b1, 8'd1, 1'b1, 56'h01_00_00_00_01_00_01);
      add_row(8'hFF, 1'b1, 8'd1, 1'b1, 56'h01_FF_00_00_01_00_01);
      add_row(8'h01, 1'b1, 8'd1, 1'b1, 56'h01_01_00_00_01_00_01);
      // Consecutive dots produce empty labels.
      add_row(8'h77, 1'b0, 8'd3, 1'b0, '0);
      add_row(SEPARATOR, 1'b0, 8'd1, 1'b0, '0);
      add_row(SEPARATOR, 1'b0, 8'd1, 1'b0, '0);
      add_row(8'h80, 1'b0, 8'd1, 1'b0, '0);
      add_row(8'h7F, 1'b0, 8'd1, 1'b0, '0);
      add_row(SEPARATOR, 1'b0, 8'd1, 1'b0, '0);
      add_row(8'h63, 1'b1, 8'd1, 1'b0, '0);
      // Overlong label, a label exactly at capacity, and an overlong final label.
      add_row(8'h78, 1'b0, 8'd40, 1'b0, '0);
      add_row(SEPARATOR, 1'b0, 8'd1, 1'b0, '0);
      add_row(8'h79, 1'b0, 8'd32, 1'b0, '0);
      add_row(SEPARATOR, 1'b0, 8'd1, 1'b0, '0);
      add_row(8'h71, 1'b1, 8'd33, 1'b0, '0);
      // Dot as the final character, once after a short label and once after an
      // overlong one.
      add_row(8'h61, 1'b0, 8'd1, 1'b0, '0);
      add_row(SEPARATOR, 1'b1, 8'd1, 1'b0, '0);
      add_row(8'h7A, 1'b0, 8'd45, 1'b0, '0);
      add_row(SEPARATOR, 1'b1, 8'd1, 1'b0, '0);

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i]) begin
         for (r = 0; r < directed_rows[i].reps; r++) begin
            d.name_char = directed_rows[i].ch;
            d.is_last_char = directed_rows[i].last && (r + 1 == directed_rows[i].reps);
            offer(d, !directed_rows[i].typed);
         end
         if (directed_rows[i].typed)
            for (k = 0; k < 7; k++)
               wire_bytes_due.push_back(octet(directed_rows[i].seq[55 - 8*k -: 8],
                                              k == 6, 1'b0));
      end

      while (sent_random < RANDOM_ITEMS) begin
         quiet = (sent_random >= 20 && sent_random < 70);
         if (!hold_sent && sent_random >= 80) begin
            hold_sent = 1'b1;
            hold_go = 1'b1;
         end
         if (!paused && sent_random >= 120) begin
            // Let the encoder drain completely before the next name.
            paused = 1'b1;
            req_valid <= 1'b0;
            @(negedge clock);
            while (wire_bytes_due.size() != 0)
               @(negedge clock);
         end
         random_name();
      end
      req_valid <= 1'b0;
      quiet = 1'b0;

      while (wire_bytes_due.size() != 0)
         @(negedge clock);
      repeat (60) @(negedge clock);
      if (mismatch_count == 0)
         $display("dns_name_label_encoder verification clean");
      else
         $display("dns_name_label_encoder verification failed");
      $finish;
   end

endmodule

@@ sim.f @@
design/dnsle_pkg.sv
design/dnsle_datapath.sv
design/dnsle_controller.sv
design/dns_name_label_encoder.sv
tb/tb.sv
